>>> rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and the byte-wide CRC-32 step for the record decoder.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int MIN_RECORD   = 27;
  localparam int HEADER_BYTES = 23;
  localparam int COUNT_OFFSET = 21;
  localparam logic [31:0] SIGNATURE = 32'h3152_4651;  // "QFR1", first byte lowest
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_COLUMNS = 2'd0;
  localparam logic [1:0] REG_MAX_STRING  = 2'd1;
  localparam logic [1:0] REG_MAX_RECORD  = 2'd2;

  // value types
  localparam logic [2:0] TY_NULL = 3'd0;
  localparam logic [2:0] TY_INT  = 3'd1;
  localparam logic [2:0] TY_REAL = 3'd2;
  localparam logic [2:0] TY_BOOL = 3'd3;
  localparam logic [2:0] TY_TEXT = 3'd4;
  localparam logic [2:0] TY_BLOB = 3'd5;

  // summary status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_SIGNATURE = 3'd2;
  localparam logic [2:0] ST_CHECKSUM  = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;
  localparam logic [2:0] ST_TYPE      = 3'd5;
  localparam logic [2:0] ST_TRAILING  = 3'd6;

  typedef struct packed {
    logic [15:0] col_limit;
    logic [31:0] text_limit;
    logic [31:0] rec_limit;
  } cfg_t;

  // first member lands in the highest bits; tdata packing is done in the top
  typedef struct packed {
    logic        result_kind;
    logic [2:0]  value_type;
    logic [63:0] value_bits;
    logic [31:0] value_length;
    logic [31:0] value_offset;
    logic [63:0] row_ident;
    logic [63:0] generation_number;
    logic        deleted_flag;
    logic [15:0] column_count;
    logic [2:0]  status;
    logic [31:0] error_offset;
  } out_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/record_frame_decoder.sv
// ----------------------------------------------------------------------------
// record_frame_decoder
// Streaming decoder of one QFR1 record: values, header and checked summary.
// ----------------------------------------------------------------------------
// Takes one record byte per cycle with no gaps of its own; each accepted byte
// is checksummed and parsed in the same cycle it leaves a four-byte delay line,
// so the trailing CRC is never parsed. Results enter a four-entry queue and are
// offered the cycle after they are pushed: a decoded value once the input byte
// that pushes its last payload byte out of the delay line is accepted (four
// bytes later), and the record summary (tlast) once the last record byte is
// accepted. Input is held off only while the queue has fewer than two free
// entries, so a sink that takes a result every cycle sees one byte per cycle
// sustained. Values are provisional; only the summary status is final.
module record_frame_decoder #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_record
  output logic         out_tvalid,
  input  logic         out_tready,
  // value_type, value_bits, value_length, value_offset, row_ident,
  // generation_number, deleted_flag, column_count, status, error_offset, pad
  output logic [311:0] out_tdata,
  output logic         out_tlast   // result_kind
);

  rfd_pkg::cfg_t      cfg_r;
  rfd_pkg::out_item_t item0, item1, head;
  logic [1:0]         push_n;
  logic               in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_limit  <= 16'd64;
      cfg_r.text_limit <= 32'd65536;
      cfg_r.rec_limit  <= 32'd1048576;
    end else if (cfg_we) begin
      case (cfg_addr)
        rfd_pkg::REG_MAX_COLUMNS: cfg_r.col_limit  <= cfg_wdata[15:0];
        rfd_pkg::REG_MAX_STRING:  cfg_r.text_limit <= cfg_wdata;
        rfd_pkg::REG_MAX_RECORD:  cfg_r.rec_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_acc = in_tvalid && in_tready;

  rfd_parser #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push_n  (push_n),
    .item0   (item0),
    .item1   (item1)
  );

  rfd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .item0     (item0),
    .item1     (item1),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (head)
  );

  assign out_tlast = head.result_kind;
  assign out_tdata = {1'b0, head.error_offset, head.status, head.column_count,
                      head.deleted_flag, head.generation_number, head.row_ident,
                      head.value_offset, head.value_length, head.value_bits,
                      head.value_type};

endmodule

>>> rtl/rfd_parser.sv
// ----------------------------------------------------------------------------
// rfd_parser
// Per-byte record state: delay line, CRC, header capture, value parse, summary.
// ----------------------------------------------------------------------------
module rfd_parser #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfd_pkg::cfg_t       cfg,
  input  logic                in_acc,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic [1:0]          push_n,
  output rfd_pkg::out_item_t  item0,
  output rfd_pkg::out_item_t  item1
);

  localparam int OW = OFFSET_WIDTH;
  localparam int SW = OW + 1;
  localparam logic [OW-1:0] POS_MAX = {OW{1'b1}};

  typedef enum logic [2:0] {
    PH_HEADER, PH_TAG, PH_NUM, PH_BOOL, PH_LEN, PH_SKIP, PH_DONE, PH_HALT
  } phase_t;

  logic [OW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [7:0]    td_r [4];
  logic [7:0]    td_nxt [4];
  phase_t        phase_r, phase_nxt;
  logic          sig_ok_r, sig_ok_nxt;
  logic [63:0]   row_r, row_nxt, gen_r, gen_nxt;
  logic          del_r, del_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic [2:0]    type_r, type_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [31:0]   left_r, left_nxt;
  logic [15:0]   cols_r, cols_nxt;
  logic          err_v_r, err_v_nxt;
  logic [2:0]    err_code_r, err_code_nxt;
  logic [OW-1:0] err_off_r, err_off_nxt;
  logic [OW-1:0] vstart_r, vstart_nxt;
  logic          colover_r, colover_nxt;

  logic [OW-1:0] p;
  logic [7:0]    b;
  logic [SW-1:0] size;
  logic [31:0]   stored, lim;
  logic          emit;
  rfd_pkg::out_item_t val, summ;

  function automatic logic [31:0] to32(input logic [OW-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  always_comb begin
    pos_nxt = pos_r;  ovf_nxt = ovf_r;  crc_nxt = crc_r;
    td_nxt = td_r;    phase_nxt = phase_r;  sig_ok_nxt = sig_ok_r;
    row_nxt = row_r;  gen_nxt = gen_r;  del_nxt = del_r;  cnt_nxt = cnt_r;
    type_nxt = type_r;  acc_nxt = acc_r;  left_nxt = left_r;  cols_nxt = cols_r;
    err_v_nxt = err_v_r;  err_code_nxt = err_code_r;  err_off_nxt = err_off_r;
    vstart_nxt = vstart_r;  colover_nxt = colover_r;
    p = pos_r - OW'(4);
    b = td_r[0];
    size = SW'(pos_r) + SW'(1);
    stored = {in_byte, td_r[3], td_r[2], td_r[1]};
    lim = '0;
    emit = 1'b0;
    val = '0;
    summ = '0;
    push_n = 2'd0;
    item0 = '0;
    item1 = '0;

    if (in_acc) begin
      if (pos_r >= OW'(4)) begin
        crc_nxt = rfd_pkg::crc_byte(crc_r, b);
        case (phase_r)
          PH_HEADER: begin
            if (p < OW'(4)) begin
              if (b != rfd_pkg::SIGNATURE[8*p[1:0] +: 8]) sig_ok_nxt = 1'b0;
            end else if (p < OW'(12)) begin
              row_nxt[8*(3'(p - OW'(4))) +: 8] = b;
            end else if (p < OW'(20)) begin
              gen_nxt[8*(3'(p - OW'(12))) +: 8] = b;
            end else if (p == OW'(20)) begin
              del_nxt = (b != 8'd0);
            end else if (p == OW'(rfd_pkg::COUNT_OFFSET)) begin
              cnt_nxt[7:0] = b;
            end else begin
              cnt_nxt[15:8] = b;
              cols_nxt = cnt_nxt;
              colover_nxt = cnt_nxt > cfg.col_limit;
              if (!sig_ok_r || colover_nxt) phase_nxt = PH_HALT;
              else phase_nxt = (cnt_nxt == 16'd0) ? PH_DONE : PH_TAG;
            end
          end
          PH_TAG: begin
            cols_nxt = cols_r - 16'd1;
            type_nxt = b[2:0];
            vstart_nxt = p + OW'(1);
            acc_nxt = '0;
            if (b == 8'd0) begin
              emit = 1'b1;
              val.value_type = rfd_pkg::TY_NULL;
              val.value_offset = to32(vstart_nxt);
              phase_nxt = (cols_nxt == 16'd0) ? PH_DONE : PH_TAG;
            end else if (b == 8'd1 || b == 8'd2) begin
              left_nxt = 32'd8;
              phase_nxt = PH_NUM;
            end else if (b == 8'd3) begin
              phase_nxt = PH_BOOL;
            end else if (b == 8'd4 || b == 8'd5) begin
              left_nxt = 32'd4;
              phase_nxt = PH_LEN;
            end else begin
              if (!err_v_r) begin
                err_v_nxt = 1'b1; err_code_nxt = rfd_pkg::ST_TYPE; err_off_nxt = p;
              end
              phase_nxt = PH_HALT;
            end
          end
          PH_NUM: begin
            acc_nxt[8*(3'(4'd8 - left_r[3:0])) +: 8] = b;
            left_nxt = left_r - 32'd1;
            if (left_nxt == 32'd0) begin
              if (type_r == rfd_pkg::TY_REAL && acc_nxt[62:52] == 11'h7FF) begin
                if (!err_v_r) begin
                  err_v_nxt = 1'b1; err_code_nxt = rfd_pkg::ST_TYPE;
                  err_off_nxt = vstart_r;
                end
                phase_nxt = PH_HALT;
              end else begin
                emit = 1'b1;
                val.value_type = type_r;
                val.value_bits = acc_nxt;
                val.value_offset = to32(vstart_r);
                phase_nxt = (cols_r == 16'd0) ? PH_DONE : PH_TAG;
              end
            end
          end
          PH_BOOL: begin
            if (b > 8'd1) begin
              if (!err_v_r) begin
                err_v_nxt = 1'b1; err_code_nxt = rfd_pkg::ST_TYPE; err_off_nxt = p;
              end
              phase_nxt = PH_HALT;
            end else begin
              emit = 1'b1;
              val.value_type = rfd_pkg::TY_BOOL;
              val.value_bits = {56'd0, b};
              val.value_offset = to32(p);
              phase_nxt = (cols_r == 16'd0) ? PH_DONE : PH_TAG;
            end
          end
          PH_LEN: begin
            acc_nxt[8*(2'(3'd4 - left_r[2:0])) +: 8] = b;
            left_nxt = left_r - 32'd1;
            if (left_nxt == 32'd0) begin
              lim = (type_r == rfd_pkg::TY_TEXT) ? cfg.text_limit
                                                 : cfg.rec_limit;
              vstart_nxt = p + OW'(1);
              if (acc_nxt[31:0] > lim) begin
                if (!err_v_r) begin
                  err_v_nxt = 1'b1; err_code_nxt = rfd_pkg::ST_LIMIT;
                  err_off_nxt = vstart_nxt;
                end
                phase_nxt = PH_HALT;
              end else begin
                left_nxt = acc_nxt[31:0];
                if (left_nxt != 32'd0) begin
                  phase_nxt = PH_SKIP;
                end else begin
                  emit = 1'b1;
                  val.value_type = type_r;
                  val.value_offset = to32(vstart_nxt);
                  phase_nxt = (cols_r == 16'd0) ? PH_DONE : PH_TAG;
                end
              end
            end
          end
          PH_SKIP: begin
            left_nxt = left_r - 32'd1;
            if (left_nxt == 32'd0) begin
              emit = 1'b1;
              val.value_type = type_r;
              val.value_length = acc_r[31:0];
              val.value_offset = to32(vstart_r);
              phase_nxt = (cols_r == 16'd0) ? PH_DONE : PH_TAG;
            end
          end
          PH_DONE: begin
            if (!err_v_r) begin
              err_v_nxt = 1'b1; err_code_nxt = rfd_pkg::ST_TRAILING; err_off_nxt = p;
            end
            phase_nxt = PH_HALT;
          end
          default: ;
        endcase
      end

      td_nxt[0] = td_r[1];
      td_nxt[1] = td_r[2];
      td_nxt[2] = td_r[3];
      td_nxt[3] = in_byte;
      if (pos_r == POS_MAX) ovf_nxt = 1'b1;
      else pos_nxt = pos_r + OW'(1);

      val.result_kind = 1'b0;
      val.row_ident = row_nxt;
      val.generation_number = gen_nxt;
      val.deleted_flag = del_nxt;
      val.column_count = cnt_nxt;

      if (in_last) begin
        summ.result_kind = 1'b1;
        summ.row_ident = row_nxt;
        summ.generation_number = gen_nxt;
        summ.deleted_flag = del_nxt;
        summ.column_count = cnt_nxt;
        if (!ovf_nxt && size < SW'(rfd_pkg::MIN_RECORD)) begin
          summ.status = rfd_pkg::ST_TRUNCATED;
        end else if (ovf_nxt || 65'(size) > 65'(cfg.rec_limit) || !sig_ok_nxt) begin
          summ.status = rfd_pkg::ST_SIGNATURE;
        end else if (~crc_nxt != stored) begin
          summ.status = rfd_pkg::ST_CHECKSUM;
          summ.error_offset = to32(OW'(size - SW'(4)));
        end else if (colover_nxt) begin
          summ.status = rfd_pkg::ST_LIMIT;
          summ.error_offset = 32'(rfd_pkg::COUNT_OFFSET);
        end else if (err_v_nxt) begin
          summ.status = err_code_nxt;
          summ.error_offset = to32(err_off_nxt);
        end else begin
          // record ended inside a value or short of its declared values; else OK
          case (phase_nxt)
            PH_TAG: begin
              summ.status = rfd_pkg::ST_TRUNCATED;
              summ.error_offset = to32(OW'(size - SW'(4)));
            end
            PH_NUM, PH_LEN: begin
              summ.status = rfd_pkg::ST_TRUNCATED;
              summ.error_offset = to32(vstart_nxt);
            end
            PH_BOOL: begin
              summ.status = rfd_pkg::ST_TYPE;
              summ.error_offset = to32(OW'(size - SW'(4)));
            end
            PH_SKIP: begin
              summ.status = rfd_pkg::ST_LIMIT;
              summ.error_offset = to32(vstart_nxt);
            end
            default: summ.status = rfd_pkg::ST_OK;
          endcase
        end

        pos_nxt = '0;  ovf_nxt = 1'b0;  crc_nxt = '1;
        td_nxt = '{default: 8'd0};
        phase_nxt = PH_HEADER;  sig_ok_nxt = 1'b1;
        row_nxt = '0;  gen_nxt = '0;  del_nxt = 1'b0;  cnt_nxt = '0;
        type_nxt = '0;  acc_nxt = '0;  left_nxt = '0;  cols_nxt = '0;
        err_v_nxt = 1'b0;  err_code_nxt = '0;  err_off_nxt = '0;
        vstart_nxt = '0;  colover_nxt = 1'b0;
      end

      if (emit) begin
        item0 = val;
        item1 = summ;
        push_n = in_last ? 2'd2 : 2'd1;
      end else if (in_last) begin
        item0 = summ;
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;  ovf_r <= 1'b0;  crc_r <= '1;
      td_r <= '{default: 8'd0};
      phase_r <= PH_HEADER;  sig_ok_r <= 1'b1;
      row_r <= '0;  gen_r <= '0;  del_r <= 1'b0;  cnt_r <= '0;
      type_r <= '0;  acc_r <= '0;  left_r <= '0;  cols_r <= '0;
      err_v_r <= 1'b0;  err_code_r <= '0;  err_off_r <= '0;
      vstart_r <= '0;  colover_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;  ovf_r <= ovf_nxt;  crc_r <= crc_nxt;
      td_r <= td_nxt;
      phase_r <= phase_nxt;  sig_ok_r <= sig_ok_nxt;
      row_r <= row_nxt;  gen_r <= gen_nxt;  del_r <= del_nxt;  cnt_r <= cnt_nxt;
      type_r <= type_nxt;  acc_r <= acc_nxt;  left_r <= left_nxt;  cols_r <= cols_nxt;
      err_v_r <= err_v_nxt;  err_code_r <= err_code_nxt;  err_off_r <= err_off_nxt;
      vstart_r <= vstart_nxt;  colover_r <= colover_nxt;
    end
  end

  a_summary_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (in_acc && in_last))
    else $error("two results without end of record");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (pos_r == '0 && phase_r == PH_HEADER && !err_v_r))
    else $error("record state not cleared after summary");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(err_v_r) && err_v_r) |-> $stable(err_off_r))
    else $error("first error overwritten");

endmodule

>>> rtl/rfd_out_queue.sv
// ----------------------------------------------------------------------------
// rfd_out_queue
// Four-entry result queue; takes up to two results a cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module rfd_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  rfd_pkg::out_item_t item0,
  input  rfd_pkg::out_item_t item1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output rfd_pkg::out_item_t out_item
);

  rfd_pkg::out_item_t q_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_item  = q_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt    = wr_r + push_n;
    rd_nxt    = rd_r + 2'(pop);
    count_nxt = count_r + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_r] <= item0;
    if (push_n == 2'd2) q_r[wr_r + 2'd1] <= item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;  rd_r <= '0;  count_r <= '0;
    end else begin
      wr_r <= wr_nxt;  rd_r <= rd_nxt;  count_r <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 3'd4) |-> (2'(wr_r - rd_r) == count_r[1:0]))
    else $error("queue pointers disagree with count");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for record_frame_decoder: streams well-formed and
// damaged records under random source gaps and sink stalls, predicts every
// value and summary transaction, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    P_HEADER, P_TAG, P_NUM, P_BOOL, P_LEN, P_SKIP, P_DONE, P_HALT
  } parse_phase_t;

  typedef enum int {
    F_NONE, F_BADSIG, F_BADCRC, F_SHORT, F_TRUNC, F_TAG, F_BOOL, F_NAN,
    F_LONG, F_TRAIL, F_COUNT, F_OVERCOL, F_NOISE
  } fault_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  vtype;
    logic [63:0] bits;
    logic [31:0] len;
    logic [31:0] off;
    logic [63:0] row;
    logic [63:0] gen;
    logic        del;
    logic [15:0] cnt;
    logic [2:0]  st;
    logic [31:0] eoff;
  } result_t;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  class record_scoreboard;
    logic [15:0]  lim_cols;
    logic [31:0]  lim_text;
    logic [31:0]  lim_rec;
    logic [31:0]  pos;
    logic [31:0]  crc;
    logic [7:0]   dly[4];
    parse_phase_t phase;
    bit           sig_ok;
    logic [63:0]  row, gen;
    logic         del;
    logic [15:0]  cnt;
    logic [7:0]   ctype;
    logic [63:0]  acc;
    logic [31:0]  left;
    logic [15:0]  cols_left;
    bit           err_valid;
    logic [2:0]   err_code;
    logic [31:0]  err_off;
    logic [31:0]  vstart;
    bit           col_over;
    result_t      expected_results[$];
    int           mismatches;

    function new();
      lim_cols = 16'd64;
      lim_text = 32'd65536;
      lim_rec  = 32'd1048576;
      mismatches = 0;
      clear_record();
    endfunction

    function void clear_record();
      pos = '0; crc = '1; dly = '{default: 8'd0}; phase = P_HEADER; sig_ok = 1'b1;
      row = '0; gen = '0; del = 1'b0; cnt = '0; ctype = '0; acc = '0; left = '0;
      cols_left = '0; err_valid = 1'b0; err_code = '0; err_off = '0; vstart = '0;
      col_over = 1'b0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] data);
      case (addr)
        rfd_pkg::REG_MAX_COLUMNS: lim_cols = data[15:0];
        rfd_pkg::REG_MAX_STRING:  lim_text = data;
        rfd_pkg::REG_MAX_RECORD:  lim_rec  = data;
        default: ;
      endcase
    endfunction

    function void push(logic kind, logic [2:0] t, logic [63:0] bits, logic [31:0] len,
                       logic [31:0] off, logic [2:0] st, logic [31:0] eoff);
      result_t r;
      r = '{kind, t, bits, len, off, row, gen, del, cnt, st, eoff};
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void flag_error(logic [2:0] code, logic [31:0] off);
      if (!err_valid) begin
        err_valid = 1'b1; err_code = code; err_off = off;
      end
      phase = P_HALT;
    endfunction

    function void after_value();
      phase = (cols_left == 16'd0) ? P_DONE : P_TAG;
    endfunction

    function void parse(logic [7:0] b, logic [31:0] p);
      crc = crc_step(crc, b);
      case (phase)
        P_HEADER: begin
          if (p < 4) begin
            if (b != rfd_pkg::SIGNATURE[8*p +: 8]) sig_ok = 1'b0;
          end else if (p < 12) row[8*(p-4) +: 8] = b;
          else if (p < 20) gen[8*(p-12) +: 8] = b;
          else if (p == 20) del = (b != 8'd0);
          else if (p == rfd_pkg::COUNT_OFFSET) cnt[7:0] = b;
          else begin
            cnt[15:8] = b;
            cols_left = cnt;
            col_over = cnt > lim_cols;
            if (!sig_ok || col_over) phase = P_HALT;
            else after_value();
          end
        end
        P_TAG: begin
          cols_left--;
          ctype = b;
          vstart = p + 32'd1;
          acc = '0;
          if (b == rfd_pkg::TY_NULL) begin
            push(1'b0, rfd_pkg::TY_NULL, '0, '0, vstart, rfd_pkg::ST_OK, '0);
            after_value();
          end else if (b == rfd_pkg::TY_INT || b == rfd_pkg::TY_REAL) begin
            left = 32'd8; phase = P_NUM;
          end else if (b == rfd_pkg::TY_BOOL) phase = P_BOOL;
          else if (b == rfd_pkg::TY_TEXT || b == rfd_pkg::TY_BLOB) begin
            left = 32'd4; phase = P_LEN;
          end else flag_error(rfd_pkg::ST_TYPE, p);
        end
        P_NUM: begin
          acc[8*(8-left) +: 8] = b;
          left--;
          if (left == 0) begin
            if (ctype == rfd_pkg::TY_REAL && acc[62:52] == 11'h7FF)
              flag_error(rfd_pkg::ST_TYPE, vstart);
            else begin
              push(1'b0, ctype[2:0], acc, '0, vstart, rfd_pkg::ST_OK, '0);
              after_value();
            end
          end
        end
        P_BOOL: begin
          if (b > 8'd1) flag_error(rfd_pkg::ST_TYPE, p);
          else begin
            push(1'b0, rfd_pkg::TY_BOOL, {63'd0, b[0]}, '0, p, rfd_pkg::ST_OK, '0);
            after_value();
          end
        end
        P_LEN: begin
          acc[8*(4-left) +: 8] = b;
          left--;
          if (left == 0) begin
            vstart = p + 32'd1;
            if (acc[31:0] > ((ctype == rfd_pkg::TY_TEXT) ? lim_text : lim_rec))
              flag_error(rfd_pkg::ST_LIMIT, vstart);
            else begin
              left = acc[31:0];
              if (left != 0) phase = P_SKIP;
              else begin
                push(1'b0, ctype[2:0], '0, '0, vstart, rfd_pkg::ST_OK, '0);
                after_value();
              end
            end
          end
        end
        P_SKIP: begin
          left--;
          if (left == 0) begin
            push(1'b0, ctype[2:0], '0, acc[31:0], vstart, rfd_pkg::ST_OK, '0);
            after_value();
          end
        end
        P_DONE: flag_error(rfd_pkg::ST_TRAILING, p);
        default: ;
      endcase
    endfunction

    // one accepted input byte
    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] size, stored;
      logic [2:0]  st;
      logic [31:0] eoff;
      if (pos >= 4) parse(dly[0], pos - 32'd4);
      dly[0] = dly[1]; dly[1] = dly[2]; dly[2] = dly[3]; dly[3] = b;
      size = pos + 32'd1;
      pos = size;
      if (last) begin
        st = rfd_pkg::ST_OK; eoff = '0;
        stored = {dly[3], dly[2], dly[1], dly[0]};
        if (size < rfd_pkg::MIN_RECORD) st = rfd_pkg::ST_TRUNCATED;
        else if (size > lim_rec || !sig_ok) st = rfd_pkg::ST_SIGNATURE;
        else if (~crc != stored) begin
          st = rfd_pkg::ST_CHECKSUM; eoff = size - 32'd4;
        end else if (col_over) begin
          st = rfd_pkg::ST_LIMIT; eoff = 32'(rfd_pkg::COUNT_OFFSET);
        end else begin
          case (phase)
            P_TAG:  flag_error(rfd_pkg::ST_TRUNCATED, size - 32'd4);
            P_NUM:  flag_error(rfd_pkg::ST_TRUNCATED, vstart);
            P_BOOL: flag_error(rfd_pkg::ST_TYPE, size - 32'd4);
            P_LEN:  flag_error(rfd_pkg::ST_TRUNCATED, vstart);
            P_SKIP: flag_error(rfd_pkg::ST_LIMIT, vstart);
            default: ;
          endcase
          if (err_valid) begin
            st = err_code; eoff = err_off;
          end
        end
        push(1'b1, rfd_pkg::TY_NULL, '0, '0, '0, st, eoff);
        clear_record();
      end
    endfunction

    // one accepted result transaction
    function void check_result(logic [311:0] d, logic last);
      result_t got, want;
      got = '{last, d[2:0], d[66:3], d[98:67], d[130:99], d[194:131], d[258:195],
              d[259], d[275:260], d[278:276], d[310:279]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result differs\n  exp %p\n  got %p", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [1:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [311:0] out_tdata;
  logic         out_tlast;

  record_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  sink_mode = 0;
  int  sink_cycle = 0;

  always #2 clk = ~clk;

  record_frame_decoder u_top (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("record_frame_decoder: mismatch");
        $finish;
      end
    end
  end

  // sink: switches at random among its stall habits
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (sink_cycle % 150 == 0) sink_mode <= $urandom_range(0, 3);
    case (sink_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (sink_cycle % 4 == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_byte(logic [7:0] b, logic last);
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_record(logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // waiting for a clock edge first lets the last accepted byte reach the scoreboard
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(addr, data);
    @(posedge clk);
  endtask

  function automatic void push_le(ref logic [7:0] q[$], input logic [63:0] v,
                                  input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), v[8*i +: 8]);
  endfunction

  // builds one record; all_types lays out one value of each type in order
  function automatic void build_record(ref logic [7:0] q[$], input fault_t fault,
                                       input bit all_types);
    int          nvals, declared, cut;
    logic [7:0]  t;
    logic [63:0] r;
    logic [31:0] len, lim, c;
    q.delete();
    if (fault == F_SHORT || fault == F_NOISE) begin
      if ($urandom_range(0, 1)) push_le(q, 64'(rfd_pkg::SIGNATURE), 4);
      repeat ((fault == F_SHORT) ? $urandom_range(0, 22) : $urandom_range(23, 56))
        q.insert(q.size(), 8'($urandom));
      if (q.size() == 0) q.insert(q.size(), 8'($urandom));
      return;
    end
    push_le(q, 64'(rfd_pkg::SIGNATURE), 4);
    if (fault == F_BADSIG) q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    push_le(q, {$urandom, $urandom}, 8);
    push_le(q, {$urandom, $urandom}, 8);
    q.insert(q.size(),
             ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
    nvals = all_types ? 6 : $urandom_range(0, (sb.lim_cols < 6) ? sb.lim_cols : 6);
    if (fault inside {F_TAG, F_BOOL, F_NAN, F_LONG} && nvals == 0) nvals = 1;
    declared = nvals;
    if (fault == F_COUNT) declared = (nvals > 0 && $urandom_range(0, 1)) ? nvals - 1 : nvals + 1;
    if (fault == F_OVERCOL && sb.lim_cols != 16'hFFFF)
      declared = sb.lim_cols + $urandom_range(1, 3);
    push_le(q, 64'(declared), 2);
    for (int i = 0; i < nvals; i++) begin
      t = all_types ? 8'(i) : 8'($urandom_range(0, 5));
      if (i == nvals - 1) begin
        if (fault == F_TAG)  t = 8'($urandom_range(6, 255));
        if (fault == F_BOOL) t = 8'(rfd_pkg::TY_BOOL);
        if (fault == F_NAN)  t = 8'(rfd_pkg::TY_REAL);
        if (fault == F_LONG) t = $urandom_range(0, 1) ? 8'(rfd_pkg::TY_TEXT)
                                                      : 8'(rfd_pkg::TY_BLOB);
      end
      q.insert(q.size(), t);
      case (t)
        rfd_pkg::TY_NULL: ;
        rfd_pkg::TY_INT, rfd_pkg::TY_REAL: begin
          r = {$urandom, $urandom};
          if ($urandom_range(0, 5) == 0) r = $urandom_range(0, 1) ? '1 : '0;
          if (t == rfd_pkg::TY_REAL) begin
            if (fault == F_NAN && i == nvals - 1) r[62:52] = '1;
            else if (r[62:52] == 11'h7FF) r[52] = 1'b0;
          end
          push_le(q, r, 8);
        end
        rfd_pkg::TY_BOOL:
          q.insert(q.size(), (fault == F_BOOL && i == nvals - 1)
                             ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1)));
        rfd_pkg::TY_TEXT, rfd_pkg::TY_BLOB: begin
          lim = (t == rfd_pkg::TY_TEXT) ? sb.lim_text : sb.lim_rec;
          len = $urandom_range(0, 5);
          if (len > lim) len = lim;
          if (fault == F_LONG && i == nvals - 1 && lim != '1) len = lim + 32'd1;
          push_le(q, 64'(len), 4);
          if (!(fault == F_LONG && i == nvals - 1))
            repeat (len) q.insert(q.size(), 8'($urandom));
        end
        default: ;
      endcase
    end
    if (fault == F_TRAIL) repeat ($urandom_range(1, 3)) q.insert(q.size(), 8'($urandom));
    if (fault == F_TRUNC) begin
      cut = $urandom_range(1, 8);
      while (cut > 0 && q.size() > rfd_pkg::HEADER_BYTES) begin
        void'(q.pop_back());
        cut--;
      end
    end
    c = '1;
    foreach (q[i]) c = crc_step(c, q[i]);
    push_le(q, 64'(~c), 4);
    if (fault == F_BADCRC)
      q[q.size() - 1 - $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
  endfunction

  task automatic run_phase(int byte_budget);
    logic [7:0] rec[$];
    int         sent, pick;
    fault_t     f;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(0, 19);
      f = (pick < 8) ? F_NONE : fault_t'(pick - 7);
      build_record(rec, f, 0);
      send_record(rec);
      sent += rec.size();
    end
    drain();
  endtask

  initial begin
    logic [7:0] rec[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every type once, then a tiny record, then a bad tag
    build_record(rec, F_NONE, 1);
    send_record(rec);
    rec = '{8'h51, 8'hFF, 8'h00};
    send_record(rec);
    build_record(rec, F_TAG, 0);
    send_record(rec);
    drain();

    run_phase(320);

    write_reg(rfd_pkg::REG_MAX_COLUMNS, 32'd0);
    write_reg(rfd_pkg::REG_MAX_STRING, 32'd0);
    write_reg(rfd_pkg::REG_MAX_RECORD, 32'd27);
    run_phase(260);

    write_reg(rfd_pkg::REG_MAX_COLUMNS, 32'hFFFF);
    write_reg(rfd_pkg::REG_MAX_STRING, 32'hFFFF_FFFF);
    write_reg(rfd_pkg::REG_MAX_RECORD, 32'hFFFF_FFFF);
    run_phase(360);

    write_reg(rfd_pkg::REG_MAX_COLUMNS, 32'd3);
    write_reg(rfd_pkg::REG_MAX_STRING, 32'd2);
    write_reg(rfd_pkg::REG_MAX_RECORD, 32'd60);
    run_phase(320);

    write_reg(rfd_pkg::REG_MAX_COLUMNS, $urandom_range(1, 8));
    write_reg(rfd_pkg::REG_MAX_STRING, $urandom_range(0, 6));
    write_reg(rfd_pkg::REG_MAX_RECORD, $urandom_range(40, 200));
    run_phase(320);

    if (sb.expected_results.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("record_frame_decoder: match");
    end else begin
      $display("record_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rfd_pkg.sv
rtl/rfd_parser.sv
rtl/rfd_out_queue.sv
rtl/record_frame_decoder.sv
verif/tb_top.sv
